// ----- src/ansi_sgr_color_decoder_unit_defines.svh -----
// Assertion macros for the SGR color decoder checker.
`ifndef ANSI_SGR_COLOR_DECODER_UNIT_DEFINES_SVH
`define ANSI_SGR_COLOR_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define ASGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define ASGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/asgr_pkg.sv -----
// Types, codes and palette tables for the SGR color decoder.
package asgr_pkg;

  // Result kinds carried in m_tuser
  localparam logic [1:0] KIND_RGB    = 2'd1;
  localparam logic [1:0] KIND_SWATCH = 2'd2;

  // Parse stages, one-hot
  typedef enum logic [5:0] {
    ST_CTRL  = 6'b000001,
    ST_FTYPE = 6'b000010,
    ST_PAL   = 6'b000100,
    ST_RED   = 6'b001000,
    ST_GREEN = 6'b010000,
    ST_BLUE  = 6'b100000
  } stage_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Standard 8-color palettes
  localparam rgb_t DARK_PAL [8] = '{
    '{8'd0,   8'd0,   8'd0},   '{8'd205, 8'd49,  8'd49},
    '{8'd13,  8'd188, 8'd121}, '{8'd229, 8'd229, 8'd16},
    '{8'd36,  8'd114, 8'd200}, '{8'd188, 8'd63,  8'd188},
    '{8'd17,  8'd168, 8'd205}, '{8'd229, 8'd229, 8'd229}
  };

  localparam rgb_t LIGHT_PAL [8] = '{
    '{8'd102, 8'd102, 8'd102}, '{8'd241, 8'd76,  8'd76},
    '{8'd35,  8'd209, 8'd139}, '{8'd245, 8'd245, 8'd67},
    '{8'd59,  8'd142, 8'd234}, '{8'd214, 8'd112, 8'd214},
    '{8'd41,  8'd184, 8'd219}, '{8'd255, 8'd255, 8'd255}
  };

  // Control codes
  localparam logic [7:0] CODE_RESET   = 8'd0;
  localparam logic [7:0] CODE_DEFAULT = 8'd39;
  localparam logic [7:0] CODE_EXT     = 8'd38;
  localparam logic [7:0] CODE_DARK    = 8'd30;
  localparam logic [7:0] CODE_LIGHT   = 8'd90;
  localparam logic [7:0] CODE_SWATCH  = 8'd110;
  localparam logic [15:0] FTYPE_RGB   = 16'd2;
  localparam logic [15:0] FTYPE_PAL   = 16'd5;
  localparam logic [15:0] VALUE_LIMIT = 16'd255;

endpackage

// ----- src/ansi_sgr_color_decoder_unit.sv -----
// SGR foreground color decoder: one parameter value per beat in, color change out.
// An accepted input beat passes through the input reg, the decode and the result reg.
// One beat per cycle unless the result stalls; one decode stage is the only logic in the path.
// Values that cause no color change produce no output beat.
// rst (sync, active high) empties both registers, parse stage to control type, held r/g to 0.
module ansi_sgr_color_decoder_unit import asgr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] value
  input  logic [0:0]  s_tuser,   // [0] first_of_sequence
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                 // [25:24] swatch_index, [31:26] zero
  output logic [1:0]  m_tuser    // [1:0] change_kind
);

  // Input register
  logic        in_valid;
  logic        in_first;
  logic [15:0] in_value;

  // Parse state
  stage_t     stage, stage_next;
  logic [7:0] held_red, held_red_next;
  logic [7:0] held_green, held_green_next;

  // Result register
  logic [1:0] out_kind;
  rgb_t       out_rgb;
  logic [1:0] out_swatch;

  // Decode outputs
  stage_t     stage_eff;
  logic       emit;
  logic [1:0] kind;
  rgb_t       rgb;
  logic [1:0] swatch;
  logic       over;
  logic [7:0] v8;
  logic       advance;

  // Cube and grey helpers
  logic [7:0]  cube_c;
  logic [15:0] prod6;
  logic [5:0]  q6;
  logic [7:0]  rem6;
  logic [11:0] prod36;
  logic [2:0]  q36;
  logic [5:0]  g6;
  logic [7:0]  grey;
  logic [7:0]  dark_idx;
  logic [7:0]  light_idx;
  logic [7:0]  sw_idx;

  // Handshake: decode stage moves when the result register can take it
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_first <= s_tuser[0];
      in_value <= s_tdata;
    end
  end

  // 6x6x6 cube digits by reciprocal multiplication (c < 216)
  always_comb begin
    v8     = in_value[7:0];
    cube_c = v8 - 8'd16;
    prod6  = 16'(cube_c) * 16'd171;
    q6     = prod6[15:10];
    rem6   = cube_c - 8'(q6) * 8'd6;
    prod36 = 12'(q6) * 12'd43;
    q36    = prod36[10:8];
    g6     = q6 - 6'(q36) * 6'd6;
    grey   = (v8 - 8'd232) * 8'd10 + 8'd8;
    dark_idx  = v8 - CODE_DARK;
    light_idx = v8 - CODE_LIGHT;
    sw_idx    = v8 - CODE_SWATCH;
  end

  // Value decode
  always_comb begin
    stage_eff       = in_first ? ST_CTRL : stage;
    stage_next      = ST_CTRL;
    held_red_next   = held_red;
    held_green_next = held_green;
    emit            = 1'b0;
    kind            = KIND_RGB;
    rgb             = '0;
    swatch          = 2'd0;
    over            = (in_value >= VALUE_LIMIT);
    unique case (stage_eff)
      ST_FTYPE: begin
        if (in_value == FTYPE_RGB) begin
          held_red_next   = 8'd0;
          held_green_next = 8'd0;
          stage_next      = ST_RED;
        end else if (in_value == FTYPE_PAL) begin
          stage_next = ST_PAL;
        end
      end
      ST_PAL: begin
        if (!over) begin
          emit = 1'b1;
          if (v8 < 8'd8) begin
            rgb = DARK_PAL[v8[2:0]];
          end else if (v8 < 8'd16) begin
            rgb = LIGHT_PAL[v8[2:0]];
          end else if (v8 < 8'd232) begin
            rgb.r = 8'(q36) * 8'd51;
            rgb.g = 8'(g6[2:0]) * 8'd51;
            rgb.b = 8'(rem6[2:0]) * 8'd51;
          end else begin
            rgb = '{grey, grey, grey};
          end
        end
      end
      ST_RED: begin
        if (!over) begin
          held_red_next = v8;
          stage_next    = ST_GREEN;
        end
      end
      ST_GREEN: begin
        if (!over) begin
          held_green_next = v8;
          stage_next      = ST_BLUE;
        end
      end
      ST_BLUE: begin
        if (!over) begin
          emit = 1'b1;
          rgb  = '{held_red, held_green, v8};
        end
      end
      default: begin
        // control type
        if (in_value == 16'(CODE_RESET) || in_value == 16'(CODE_DEFAULT)) begin
          emit = 1'b1;
          kind = KIND_SWATCH;
        end else if (!over && v8 >= CODE_DARK && v8 < CODE_DARK + 8'd8) begin
          emit = 1'b1;
          rgb  = DARK_PAL[dark_idx[2:0]];
        end else if (!over && v8 >= CODE_LIGHT && v8 < CODE_LIGHT + 8'd8) begin
          emit = 1'b1;
          rgb  = LIGHT_PAL[light_idx[2:0]];
        end else if (!over && v8 >= CODE_SWATCH && v8 < CODE_SWATCH + 8'd4) begin
          emit   = 1'b1;
          kind   = KIND_SWATCH;
          swatch = sw_idx[1:0];
        end else if (in_value == 16'(CODE_EXT)) begin
          stage_next = ST_FTYPE;
        end
      end
    endcase
  end

  // Parse state update
  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= ST_CTRL;
      held_red   <= 8'd0;
      held_green <= 8'd0;
    end else if (advance) begin
      stage      <= stage_next;
      held_red   <= held_red_next;
      held_green <= held_green_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= advance && emit;
    end
    if (advance && emit) begin
      out_kind   <= kind;
      out_rgb    <= rgb;
      out_swatch <= swatch;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {6'd0, out_swatch, out_rgb.b, out_rgb.g, out_rgb.r};

endmodule

// ----- src/asgr_checker.sv -----
// Port-level checker for the SGR color decoder, bound to the top level.
`include "ansi_sgr_color_decoder_unit_defines.svh"

module asgr_checker import asgr_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // Stalled result beat holds
  `ASGR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

  // Only the two result kinds appear
  `ASGR_ASSERT_NOW(a_kind_legal, m_tvalid, m_tuser == KIND_RGB || m_tuser == KIND_SWATCH, "illegal change kind")

  // Swatch changes carry no color
  `ASGR_ASSERT_NOW(a_swatch_clean, m_tvalid && m_tuser == KIND_SWATCH, m_tdata[23:0] == 24'd0, "swatch beat with color bits")

  // RGB changes carry no swatch, and padding stays zero
  `ASGR_ASSERT_NOW(a_rgb_clean, m_tvalid && m_tuser == KIND_RGB, m_tdata[31:24] == 8'd0, "rgb beat with swatch or pad bits")

endmodule

bind ansi_sgr_color_decoder_unit asgr_checker u_asgr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
